// ===== src/sphere_pair_collision_response_macros.svh =====
// ----------------------------------------------------------------------------
// sphere pair collision response - assertion macros
// immediate-cycle and next-cycle implication checks, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef SPHERE_PAIR_COLLISION_RESPONSE_MACROS_SVH
`define SPHERE_PAIR_COLLISION_RESPONSE_MACROS_SVH
`ifndef SYNTH
`define SPCR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spcr check failed");
`define SPCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spcr check failed");
`else
`define SPCR_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SPCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/spcr_pkg.sv =====
// ----------------------------------------------------------------------------
// spcr_pkg
// shared widths, command and status types and rounding helpers
// ----------------------------------------------------------------------------
package spcr_pkg;

    localparam int WORD_W    = 32;
    localparam int DIFF_W    = WORD_W + 1;
    localparam int MAG_W     = WORD_W - 1;
    localparam int REST_W    = 17;
    localparam int AXIS_FRAC = 30;
    localparam int VEL_FRAC  = 16;
    localparam int SW        = 64;
    localparam int MA_W      = 64;
    localparam int MB_W      = 40;
    localparam int NUM_W     = 96;
    localparam int DEN_W     = 64;
    localparam int RAD_W     = 68;
    localparam int SQ_STEPS  = RAD_W / 2;
    localparam int RES_W     = 128;
    localparam int REM_W     = DEN_W + 1;
    localparam int CNT_W     = $clog2(NUM_W);

    localparam logic [REST_W-1:0] REST_RESET = REST_W'(32768);
    localparam logic [REST_W-1:0] REST_ONE   = REST_W'(65536);

    typedef enum logic [1:0] {
        IT_MUL,
        IT_DIV,
        IT_SQRT
    } t_iter_op;

    typedef enum logic [3:0] {
        STEP_DSQ,
        STEP_SUMR,
        STEP_SQRT,
        STEP_AXIS,
        STEP_UA,
        STEP_UB,
        STEP_ME,
        STEP_MR,
        STEP_MDIV,
        STEP_NEWV
    } t_step;

    typedef struct packed {
        logic       load_a;
        logic       load_b;
        logic       start;
        logic       finish;
        t_step      step;
        logic [2:0] idx;
    } t_cmd;

    typedef struct packed {
        logic iter_done;
        logic hit;
        logic approach;
    } t_stat;

    // signed value rounded half up after dropping sh low bits
    function automatic logic signed [RES_W-1:0] round_shift(
        input logic signed [RES_W-1:0] v,
        input int unsigned             sh
    );
        logic signed [RES_W-1:0] half;
        logic signed [RES_W-1:0] sum;
        half = $signed(RES_W'(1) << (sh - 1));
        sum  = v + half;
        return sum >>> sh;
    endfunction

    function automatic logic signed [WORD_W-1:0] sat_word(
        input logic signed [RES_W-1:0] v
    );
        logic signed [RES_W-1:0] wmax;
        logic signed [RES_W-1:0] wmin;
        wmax = $signed((RES_W'(1) << (WORD_W - 1)) - RES_W'(1));
        wmin = -wmax - $signed(RES_W'(1));
        if (v > wmax) begin
            return wmax[WORD_W-1:0];
        end else if (v < wmin) begin
            return wmin[WORD_W-1:0];
        end
        return v[WORD_W-1:0];
    endfunction

endpackage

// ===== src/spcr_iter.sv =====
// ----------------------------------------------------------------------------
// spcr_iter
// shared bit-serial unit: shift-add multiply, restoring divide, square root
// ----------------------------------------------------------------------------
`include "sphere_pair_collision_response_macros.svh"
module spcr_iter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  spcr_pkg::t_iter_op         i_op,
    input  logic [spcr_pkg::NUM_W-1:0] i_x,
    input  logic [spcr_pkg::DEN_W-1:0] i_y,
    output logic                       o_done,
    output logic [spcr_pkg::RES_W-1:0] o_res
);
    import spcr_pkg::*;

    logic             r_busy;
    logic             r_done;
    t_iter_op         r_op;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_x;
    logic [DEN_W-1:0] r_y;
    logic [RES_W-1:0] r_mc;
    logic [RES_W-1:0] r_acc;
    logic [REM_W-1:0] r_rem;

    logic [REM_W:0] div_sh;
    logic           div_ge;
    logic [REM_W:0] sq_sh;
    logic [REM_W:0] sq_trial;
    logic           sq_ge;

    always_comb begin
        div_sh   = {r_rem, r_x[NUM_W-1]};
        div_ge   = div_sh >= {2'b00, r_y};
        sq_sh    = {r_rem[REM_W-2:0], r_x[NUM_W-1 -: 2]};
        sq_trial = {r_acc[REM_W-2:0], 2'b01};
        sq_ge    = sq_sh >= sq_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_op   <= i_op;
                r_acc  <= '0;
                r_rem  <= '0;
                r_y    <= i_y;
                r_mc   <= RES_W'(i_x[MA_W-1:0]);
                case (i_op)
                    IT_MUL: begin
                        r_cnt <= CNT_W'(MB_W - 1);
                        r_x   <= i_x;
                    end
                    IT_DIV: begin
                        r_cnt <= CNT_W'(NUM_W - 1);
                        r_x   <= i_x;
                    end
                    IT_SQRT: begin
                        r_cnt <= CNT_W'(SQ_STEPS - 1);
                        r_x   <= {i_x[RAD_W-1:0], {(NUM_W - RAD_W){1'b0}}};
                    end
                    default: begin
                        r_cnt <= '0;
                        r_x   <= i_x;
                    end
                endcase
            end else if (r_busy) begin
                case (r_op)
                    IT_MUL: begin
                        if (r_y[0]) begin
                            r_acc <= r_acc + r_mc;
                        end
                        r_mc <= r_mc << 1;
                        r_y  <= r_y >> 1;
                    end
                    IT_DIV: begin
                        r_rem <= div_ge ? REM_W'(div_sh - {2'b00, r_y}) : REM_W'(div_sh);
                        r_acc <= {r_acc[RES_W-2:0], div_ge};
                        r_x   <= r_x << 1;
                    end
                    IT_SQRT: begin
                        r_rem <= sq_ge ? REM_W'(sq_sh - sq_trial) : REM_W'(sq_sh);
                        r_acc <= {r_acc[RES_W-2:0], sq_ge};
                        r_x   <= r_x << 2;
                    end
                    default: begin
                        r_acc <= r_acc;
                    end
                endcase
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc;

    `SPCR_ASSERT_NOW(a_no_restart, i_clk, i_rst_n, i_start, !r_busy)
    `SPCR_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done)

endmodule

// ===== src/spcr_dp.sv =====
// ----------------------------------------------------------------------------
// spcr_dp
// datapath: held body a, body b, axis, projections and velocity updates
// ----------------------------------------------------------------------------
module spcr_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  spcr_pkg::t_cmd                       i_cmd,
    output spcr_pkg::t_stat                      o_stat,
    input  logic                                 i_cfg_we,
    input  logic [spcr_pkg::REST_W-1:0]          i_cfg_data,
    input  logic [2:0][spcr_pkg::WORD_W-1:0]     i_pos,
    input  logic [2:0][spcr_pkg::WORD_W-1:0]     i_vel,
    input  logic [spcr_pkg::MAG_W-1:0]           i_radius,
    input  logic [spcr_pkg::MAG_W-1:0]           i_mass,
    input  logic                                 i_sel,
    output logic [2:0][spcr_pkg::WORD_W-1:0]     o_vel,
    output logic                                 o_collided
);
    import spcr_pkg::*;

    logic signed [WORD_W-1:0] r_pa [3];
    logic signed [WORD_W-1:0] r_va [3];
    logic signed [WORD_W-1:0] r_vb [3];
    logic signed [WORD_W-1:0] r_ax [3];
    logic signed [WORD_W-1:0] r_na [3];
    logic signed [WORD_W-1:0] r_nb [3];
    logic signed [DIFF_W-1:0] r_d  [3];
    logic [MAG_W-1:0]         r_ra, r_ma, r_rb, r_mb;
    logic [RES_W-1:0]         r_acc;
    logic                     r_col, r_hit;
    logic [SQ_STEPS-1:0]      r_dist;
    logic signed [SW-1:0]     r_ua, r_r, r_da, r_db;
    logic [NUM_W-1:0]         r_t;
    logic [REST_W-1:0]        r_rest;

    logic                     side;
    logic [1:0]               k;
    logic [DIFF_W-1:0]        absd;
    logic [WORD_W-1:0]        absax, absva, absvb;
    logic signed [SW-1:0]     dsel;
    logic [SW-1:0]            absdel;
    logic [WORD_W-1:0]        rsum, msum;
    logic [REST_W-1:0]        e_cl;
    logic [REST_W:0]          e_eff;
    logic [MAG_W-1:0]         m_other;

    t_iter_op                 it_op;
    logic [NUM_W-1:0]         it_x;
    logic [DEN_W-1:0]         it_y;
    logic                     it_done;
    logic [RES_W-1:0]         it_res;
    logic                     neg;

    logic signed [RES_W-1:0]  sres, acc_base, sum_dot, vbase, nv_wide;
    logic signed [WORD_W-1:0] nv;
    logic [RES_W-1:0]         rq;
    logic [WORD_W-1:0]        aq1, amag;

    function automatic logic idx_ge3(input logic [2:0] idx);
        return idx >= 3'd3;
    endfunction

    always_comb begin
        side    = idx_ge3(i_cmd.idx);
        k       = side ? 2'(i_cmd.idx - 3'd3) : i_cmd.idx[1:0];
        absd    = r_d[k][DIFF_W-1] ? DIFF_W'(-r_d[k]) : DIFF_W'(r_d[k]);
        absax   = r_ax[k][WORD_W-1] ? WORD_W'(-r_ax[k]) : WORD_W'(r_ax[k]);
        absva   = r_va[k][WORD_W-1] ? WORD_W'(-r_va[k]) : WORD_W'(r_va[k]);
        absvb   = r_vb[k][WORD_W-1] ? WORD_W'(-r_vb[k]) : WORD_W'(r_vb[k]);
        dsel    = side ? r_db : r_da;
        absdel  = dsel[SW-1] ? SW'(-dsel) : SW'(dsel);
        rsum    = WORD_W'(r_ra) + WORD_W'(r_rb);
        msum    = WORD_W'(r_ma) + WORD_W'(r_mb);
        e_cl    = (r_rest > REST_ONE) ? REST_ONE : r_rest;
        e_eff   = {1'b0, e_cl} + {1'b0, REST_ONE};
        m_other = i_cmd.idx[0] ? r_ma : r_mb;

        it_op = IT_MUL;
        it_x  = '0;
        it_y  = '0;
        neg   = 1'b0;
        case (i_cmd.step)
            STEP_DSQ: begin
                it_x = NUM_W'(absd);
                it_y = DEN_W'(absd);
            end
            STEP_SUMR: begin
                it_x = NUM_W'(rsum);
                it_y = DEN_W'(rsum);
            end
            STEP_SQRT: begin
                it_op = IT_SQRT;
                it_x  = NUM_W'(r_acc[RAD_W-1:0]);
            end
            STEP_AXIS: begin
                it_op = IT_DIV;
                it_x  = NUM_W'(absd) << (AXIS_FRAC + 1);
                it_y  = DEN_W'(r_dist);
            end
            STEP_UA: begin
                it_x = NUM_W'(absva);
                it_y = DEN_W'(absax);
                neg  = r_va[k][WORD_W-1] ^ r_ax[k][WORD_W-1];
            end
            STEP_UB: begin
                it_x = NUM_W'(absvb);
                it_y = DEN_W'(absax);
                neg  = r_vb[k][WORD_W-1] ^ r_ax[k][WORD_W-1];
            end
            STEP_ME: begin
                it_x = NUM_W'(m_other);
                it_y = DEN_W'(e_eff);
            end
            STEP_MR: begin
                it_x = r_t;
                it_y = DEN_W'(r_r);
            end
            STEP_MDIV: begin
                it_op = IT_DIV;
                it_x  = r_t;
                it_y  = DEN_W'(msum);
            end
            STEP_NEWV: begin
                it_x = NUM_W'(absdel);
                it_y = DEN_W'(absax);
                neg  = dsel[SW-1] ^ r_ax[k][WORD_W-1];
            end
            default: begin
                it_op = IT_MUL;
            end
        endcase

        sres     = neg ? -$signed(it_res) : $signed(it_res);
        acc_base = (i_cmd.idx == 3'd0) ? '0 : $signed(r_acc);
        sum_dot  = acc_base + sres;
        vbase    = side ? RES_W'(r_nb[k]) : RES_W'(r_na[k]);
        nv_wide  = vbase + round_shift(sres, AXIS_FRAC);
        nv       = sat_word(nv_wide);
        rq       = it_res + (RES_W'(1) << (VEL_FRAC - 1));
        aq1      = it_res[WORD_W-1:0] + WORD_W'(1);
        amag     = aq1 >> 1;
    end

    spcr_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_op    (it_op),
        .i_x     (it_x),
        .i_y     (it_y),
        .o_done  (it_done),
        .o_res   (it_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest <= REST_RESET;
            r_ra   <= '0;
            r_ma   <= '0;
            for (int i = 0; i < 3; i++) begin
                r_pa[i] <= '0;
                r_va[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_rest <= i_cfg_data;
            end
            if (i_cmd.load_a) begin
                for (int i = 0; i < 3; i++) begin
                    r_pa[i] <= $signed(i_pos[i]);
                    r_va[i] <= $signed(i_vel[i]);
                end
                r_ra <= i_radius;
                r_ma <= i_mass;
            end
            if (i_cmd.load_b) begin
                for (int i = 0; i < 3; i++) begin
                    r_vb[i] <= $signed(i_vel[i]);
                    r_nb[i] <= $signed(i_vel[i]);
                    r_na[i] <= r_va[i];
                    r_d[i]  <= DIFF_W'(r_pa[i]) - DIFF_W'($signed(i_pos[i]));
                end
                r_rb <= i_radius;
                r_mb <= i_mass;
            end
            if (i_cmd.finish) begin
                case (i_cmd.step)
                    STEP_DSQ: begin
                        r_acc <= ((i_cmd.idx == 3'd0) ? '0 : r_acc) + it_res;
                    end
                    STEP_SUMR: begin
                        r_col <= r_acc <= it_res;
                        r_hit <= (r_acc <= it_res) && (r_acc != '0);
                    end
                    STEP_SQRT: begin
                        r_dist <= it_res[SQ_STEPS-1:0];
                    end
                    STEP_AXIS: begin
                        r_ax[k] <= r_d[k][DIFF_W-1] ? -$signed(amag) : $signed(amag);
                    end
                    STEP_UA: begin
                        r_acc <= sum_dot;
                        if (i_cmd.idx == 3'd2) begin
                            r_ua <= SW'(round_shift(sum_dot, AXIS_FRAC));
                        end
                    end
                    STEP_UB: begin
                        r_acc <= sum_dot;
                        if (i_cmd.idx == 3'd2) begin
                            r_r <= SW'(round_shift(sum_dot, AXIS_FRAC)) - r_ua;
                        end
                    end
                    STEP_ME, STEP_MR: begin
                        r_t <= it_res[NUM_W-1:0];
                    end
                    STEP_MDIV: begin
                        if (i_cmd.idx[0]) begin
                            r_db <= -$signed(SW'(rq >> VEL_FRAC));
                        end else begin
                            r_da <= $signed(SW'(rq >> VEL_FRAC));
                        end
                    end
                    STEP_NEWV: begin
                        if (side) begin
                            r_nb[k] <= nv;
                        end else begin
                            r_na[k] <= nv;
                        end
                    end
                    default: begin
                        r_t <= r_t;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_stat.iter_done = it_done;
        o_stat.hit       = r_hit;
        o_stat.approach  = (r_r > $signed(SW'(0))) && (msum != '0);
        for (int i = 0; i < 3; i++) begin
            o_vel[i] = i_sel ? r_nb[i] : r_na[i];
        end
        o_collided = r_col;
    end

endmodule

// ===== src/spcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// spcr_ctrl
// sequencer for the pair computation and the two result transfers
// ----------------------------------------------------------------------------
`include "sphere_pair_collision_response_macros.svh"
module spcr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic            i_second,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic            o_sel,
    output logic            o_last,
    output spcr_pkg::t_cmd  o_cmd,
    input  spcr_pkg::t_stat i_stat
);
    import spcr_pkg::*;

    typedef enum logic [14:0] {
        ST_IDLE   = 15'b000000000000001,
        ST_DSQ    = 15'b000000000000010,
        ST_SUMR   = 15'b000000000000100,
        ST_HIT    = 15'b000000000001000,
        ST_SQRT   = 15'b000000000010000,
        ST_AXIS   = 15'b000000000100000,
        ST_UA     = 15'b000000001000000,
        ST_UB     = 15'b000000010000000,
        ST_APPR   = 15'b000000100000000,
        ST_ME     = 15'b000001000000000,
        ST_MR     = 15'b000010000000000,
        ST_MDIV   = 15'b000100000000000,
        ST_NEWV   = 15'b001000000000000,
        ST_EMIT_A = 15'b010000000000000,
        ST_EMIT_B = 15'b100000000000000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_idx, n_idx;
    logic       r_wait, n_wait;
    logic       calc;
    logic       adv;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_wait      = r_wait;
        o_cmd       = '0;
        o_cmd.idx   = r_idx;
        o_cmd.step  = STEP_DSQ;
        calc        = 1'b0;
        o_in_stall  = r_state != ST_IDLE;
        o_out_valid = (r_state == ST_EMIT_A) || (r_state == ST_EMIT_B);
        o_sel       = r_state == ST_EMIT_B;
        o_last      = r_state == ST_EMIT_B;

        unique case (r_state)
            ST_DSQ:  begin calc = 1'b1; o_cmd.step = STEP_DSQ;  end
            ST_SUMR: begin calc = 1'b1; o_cmd.step = STEP_SUMR; end
            ST_SQRT: begin calc = 1'b1; o_cmd.step = STEP_SQRT; end
            ST_AXIS: begin calc = 1'b1; o_cmd.step = STEP_AXIS; end
            ST_UA:   begin calc = 1'b1; o_cmd.step = STEP_UA;   end
            ST_UB:   begin calc = 1'b1; o_cmd.step = STEP_UB;   end
            ST_ME:   begin calc = 1'b1; o_cmd.step = STEP_ME;   end
            ST_MR:   begin calc = 1'b1; o_cmd.step = STEP_MR;   end
            ST_MDIV: begin calc = 1'b1; o_cmd.step = STEP_MDIV; end
            ST_NEWV: begin calc = 1'b1; o_cmd.step = STEP_NEWV; end
            default: begin calc = 1'b0; end
        endcase

        adv = 1'b0;
        if (calc) begin
            if (!r_wait) begin
                o_cmd.start = 1'b1;
                n_wait      = 1'b1;
            end else if (i_stat.iter_done) begin
                o_cmd.finish = 1'b1;
                n_wait       = 1'b0;
                adv          = 1'b1;
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_second) begin
                        o_cmd.load_b = 1'b1;
                        n_state      = ST_DSQ;
                        n_idx        = 3'd0;
                    end else begin
                        o_cmd.load_a = 1'b1;
                    end
                end
            end
            ST_DSQ: begin
                if (adv) begin
                    if (r_idx == 3'd2) begin
                        n_state = ST_SUMR;
                        n_idx   = 3'd0;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            ST_SUMR: begin
                if (adv) begin
                    n_state = ST_HIT;
                end
            end
            ST_HIT: begin
                n_state = i_stat.hit ? ST_SQRT : ST_EMIT_A;
            end
            ST_SQRT: begin
                if (adv) begin
                    n_state = ST_AXIS;
                    n_idx   = 3'd0;
                end
            end
            ST_AXIS: begin
                if (adv) begin
                    if (r_idx == 3'd2) begin
                        n_state = ST_UA;
                        n_idx   = 3'd0;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            ST_UA: begin
                if (adv) begin
                    if (r_idx == 3'd2) begin
                        n_state = ST_UB;
                        n_idx   = 3'd0;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            ST_UB: begin
                if (adv) begin
                    if (r_idx == 3'd2) begin
                        n_state = ST_APPR;
                        n_idx   = 3'd0;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            ST_APPR: begin
                n_state = i_stat.approach ? ST_ME : ST_EMIT_A;
                n_idx   = 3'd0;
            end
            ST_ME: begin
                if (adv) begin
                    n_state = ST_MR;
                end
            end
            ST_MR: begin
                if (adv) begin
                    n_state = ST_MDIV;
                end
            end
            ST_MDIV: begin
                if (adv) begin
                    if (r_idx == 3'd0) begin
                        n_state = ST_ME;
                        n_idx   = 3'd1;
                    end else begin
                        n_state = ST_NEWV;
                        n_idx   = 3'd0;
                    end
                end
            end
            ST_NEWV: begin
                if (adv) begin
                    if (r_idx == 3'd5) begin
                        n_state = ST_EMIT_A;
                        n_idx   = 3'd0;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            ST_EMIT_A: begin
                if (!i_out_stall) begin
                    n_state = ST_EMIT_B;
                end
            end
            ST_EMIT_B: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= 3'd0;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_wait  <= n_wait;
        end
    end

    `SPCR_ASSERT_NOW(a_stall_while_out, i_clk, i_rst_n, o_out_valid, o_in_stall)
    `SPCR_ASSERT_NOW(a_done_when_waiting, i_clk, i_rst_n, i_stat.iter_done, r_wait)
    `SPCR_ASSERT_NEXT(a_pair_ends, i_clk, i_rst_n, o_out_valid && o_last && !i_out_stall, !o_out_valid && !o_in_stall)

endmodule

// ===== src/sphere_pair_collision_response.sv =====
// body a is taken and gives no result
// body b: an approaching overlap runs every step, an overlap not closing stops after the
// projections, one apart or coincident after the overlap test; results back to back unless stalled
// all arithmetic runs on the single bit-serial unit: multiply, divide and the root
// one pair at a time; a new body is taken only once both results have been transferred
// reset (synchronous, active low) clears body a to zero and restitution to one half
// ----------------------------------------------------------------------------
// sphere_pair_collision_response
// inelastic sphere pair collision response along the centre axis
// ----------------------------------------------------------------------------
module sphere_pair_collision_response (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // body channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [spcr_pkg::WORD_W-1:0]  i_pos_x,
    input  logic signed [spcr_pkg::WORD_W-1:0]  i_pos_y,
    input  logic signed [spcr_pkg::WORD_W-1:0]  i_pos_z,
    input  logic signed [spcr_pkg::WORD_W-1:0]  i_vel_x,
    input  logic signed [spcr_pkg::WORD_W-1:0]  i_vel_y,
    input  logic signed [spcr_pkg::WORD_W-1:0]  i_vel_z,
    input  logic [spcr_pkg::MAG_W-1:0]          i_radius,
    input  logic [spcr_pkg::MAG_W-1:0]          i_mass,
    input  logic                                i_second_of_pair,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_body_select,
    output logic signed [spcr_pkg::WORD_W-1:0]  o_new_vel_x,
    output logic signed [spcr_pkg::WORD_W-1:0]  o_new_vel_y,
    output logic signed [spcr_pkg::WORD_W-1:0]  o_new_vel_z,
    output logic                                o_collided,
    output logic                                o_last_of_pair,
    // restitution write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [spcr_pkg::REST_W-1:0]         i_restitution
);
    import spcr_pkg::*;

    t_cmd                    cmd;
    t_stat                   stat;
    logic                    sel;
    logic [2:0][WORD_W-1:0]  pos_in;
    logic [2:0][WORD_W-1:0]  vel_in;
    logic [2:0][WORD_W-1:0]  vel_out;

    // the user must change restitution only between pairs; the block takes every write unchecked
    assign o_cfg_ready = 1'b1;

    assign pos_in = {i_pos_z, i_pos_y, i_pos_x};
    assign vel_in = {i_vel_z, i_vel_y, i_vel_x};

    // sequencer: body transfers, step order, result transfers
    spcr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_second    (i_second_of_pair),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sel       (sel),
        .o_last      (o_last_of_pair),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // datapath with the held body, the arithmetic unit and result registers
    spcr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_restitution),
        .i_pos      (pos_in),
        .i_vel      (vel_in),
        .i_radius   (i_radius),
        .i_mass     (i_mass),
        .i_sel      (sel),
        .o_vel      (vel_out),
        .o_collided (o_collided)
    );

    // results come straight from the velocity registers, stable while stalled
    assign o_body_select = sel;
    assign o_new_vel_x   = vel_out[0];
    assign o_new_vel_y   = vel_out[1];
    assign o_new_vel_z   = vel_out[2];

endmodule

// ===== test/sphere_pair_response_checker.sv =====
// ----------------------------------------------------------------------------
// sphere_pair_response_checker
// watches the body, result and restitution channels, predicts the velocity
// pair for every body b and compares each result transfer field by field
// ----------------------------------------------------------------------------
module sphere_pair_response_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic signed [spcr_pkg::WORD_W-1:0] i_pos_x,
    input  logic signed [spcr_pkg::WORD_W-1:0] i_pos_y,
    input  logic signed [spcr_pkg::WORD_W-1:0] i_pos_z,
    input  logic signed [spcr_pkg::WORD_W-1:0] i_vel_x,
    input  logic signed [spcr_pkg::WORD_W-1:0] i_vel_y,
    input  logic signed [spcr_pkg::WORD_W-1:0] i_vel_z,
    input  logic [spcr_pkg::MAG_W-1:0]         i_radius,
    input  logic [spcr_pkg::MAG_W-1:0]         i_mass,
    input  logic                               i_second_of_pair,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic                               i_body_select,
    input  logic signed [spcr_pkg::WORD_W-1:0] i_new_vel_x,
    input  logic signed [spcr_pkg::WORD_W-1:0] i_new_vel_y,
    input  logic signed [spcr_pkg::WORD_W-1:0] i_new_vel_z,
    input  logic                               i_collided,
    input  logic                               i_last_of_pair,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [spcr_pkg::REST_W-1:0]        i_restitution,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    typedef longint vec3_t [3];

    typedef struct packed {
        logic                               body_select;
        logic signed [spcr_pkg::WORD_W-1:0] vx;
        logic signed [spcr_pkg::WORD_W-1:0] vy;
        logic signed [spcr_pkg::WORD_W-1:0] vz;
        logic                               collided;
        logic                               last_of_pair;
    } vel_result_t;

    vel_result_t              exp_vel_q[$];
    logic [spcr_pkg::REST_W-1:0] rest_q16;
    vec3_t                    a_pos;
    vec3_t                    a_vel;
    logic [63:0]              a_rad;
    logic [63:0]              a_mass;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    // signed value rounded half up after dropping the axis fraction
    function automatic longint round30(input logic signed [127:0] x);
        logic signed [127:0] t;
        t = x + (128'sd1 <<< 29);
        return $signed(t[93:30]);
    endfunction

    function automatic longint project(input vec3_t v, input vec3_t ax);
        logic signed [127:0] s;
        logic signed [127:0] wv;
        logic signed [127:0] wa;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            wv = v[i];
            wa = ax[i];
            s = s + wv * wa;
        end
        return round30(s);
    endfunction

    // momentum share along the axis for the body whose partner weighs m_other
    function automatic longint axis_dv(input logic [63:0] m_other, input logic [63:0] msum,
                                       input logic [63:0] e, input logic [63:0] rel);
        logic [63:0]  me;
        logic [127:0] q;
        me = m_other * e;
        q  = ({64'd0, me} * {64'd0, rel}) / {64'd0, msum};
        q  = q + 128'd32768;
        return $signed(q[79:16]);
    endfunction

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    task automatic take_body();
        vec3_t               pb;
        vec3_t               vb;
        vec3_t               na;
        vec3_t               nb;
        vec3_t               ax;
        longint              d;
        longint              ua;
        longint              ub;
        longint              rel;
        longint              dva;
        longint              dvb;
        logic [63:0]         mag;
        logic [63:0]         rb;
        logic [63:0]         mb;
        logic [63:0]         sumr;
        logic [63:0]         centre_gap;
        logic [63:0]         cand;
        logic [63:0]         ql;
        logic [63:0]         e;
        logic [127:0]        dd;
        logic [127:0]        q;
        logic signed [127:0] wa;
        logic signed [127:0] wd;
        logic                hit;
        pb[0] = i_pos_x; pb[1] = i_pos_y; pb[2] = i_pos_z;
        vb[0] = i_vel_x; vb[1] = i_vel_y; vb[2] = i_vel_z;
        rb = {33'd0, i_radius};
        mb = {33'd0, i_mass};
        if (!i_second_of_pair) begin
            // body a: held until its partner arrives
            a_pos  = pb;
            a_vel  = vb;
            a_rad  = rb;
            a_mass = mb;
            return;
        end
        dd = 0;
        d  = 0;
        for (int i = 0; i < 3; i++) begin
            d   = a_pos[i] - pb[i];
            mag = d < 0 ? -d : d;
            dd  = dd + {64'd0, mag} * {64'd0, mag};
            na[i] = a_vel[i];
            nb[i] = vb[i];
        end
        sumr = a_rad + rb;
        hit  = dd <= {64'd0, sumr} * {64'd0, sumr};
        if (hit && dd != 0) begin
            centre_gap = 0;
            for (int b = 34; b >= 0; b--) begin
                cand = centre_gap | (64'd1 << b);
                if ({64'd0, cand} * {64'd0, cand} <= dd) centre_gap = cand;
            end
            // unit axis from b to a in q1.30, one extra bit for rounding
            for (int i = 0; i < 3; i++) begin
                d   = a_pos[i] - pb[i];
                mag = d < 0 ? -d : d;
                q   = ({64'd0, mag} << 31) / {64'd0, centre_gap};
                ql  = q[63:0] + 64'd1;
                ql  = ql >> 1;
                ax[i] = d < 0 ? -$signed(ql) : $signed(ql);
            end
            ua  = project(a_vel, ax);
            ub  = project(vb, ax);
            rel = ub - ua;
            if (rel > 0 && a_mass + mb != 0) begin
                e   = (rest_q16 > spcr_pkg::REST_ONE ? 64'd65536 : {47'd0, rest_q16}) + 64'd65536;
                dva = axis_dv(mb, a_mass + mb, e, rel);
                dvb = -axis_dv(a_mass, a_mass + mb, e, rel);
                for (int i = 0; i < 3; i++) begin
                    wa = ax[i];
                    wd = dva;
                    na[i] = sat32(na[i] + round30(wa * wd));
                    wd = dvb;
                    nb[i] = sat32(nb[i] + round30(wa * wd));
                end
            end
        end
        exp_vel_q.push_back({1'b0, na[0][31:0], na[1][31:0], na[2][31:0], hit, 1'b0});
        exp_vel_q.push_back({1'b1, nb[0][31:0], nb[1][31:0], nb[2][31:0], hit, 1'b1});
    endtask

    task automatic check_result();
        vel_result_t want;
        if (exp_vel_q.size() == 0) begin
            report("unexpected result transfer", i_body_select, -1);
            return;
        end
        want = exp_vel_q.pop_front();
        if (i_body_select != want.body_select) report("body_select", i_body_select, want.body_select);
        if (i_new_vel_x != want.vx) report("new_vel_x", i_new_vel_x, want.vx);
        if (i_new_vel_y != want.vy) report("new_vel_y", i_new_vel_y, want.vy);
        if (i_new_vel_z != want.vz) report("new_vel_z", i_new_vel_z, want.vz);
        if (i_collided != want.collided) report("collided", i_collided, want.collided);
        if (i_last_of_pair != want.last_of_pair) report("last_of_pair", i_last_of_pair, want.last_of_pair);
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rest_q16 = spcr_pkg::REST_RESET;
            for (int i = 0; i < 3; i++) begin
                a_pos[i] = 0;
                a_vel[i] = 0;
            end
            a_rad  = 0;
            a_mass = 0;
            exp_vel_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) rest_q16 = i_restitution;
            if (i_out_valid && !i_out_stall) check_result();
            if (i_in_valid && !i_in_stall) take_body();
        end
        o_pending = exp_vel_q.size();
    end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives bodies and restitution writes into the sphere pair collision block,
// varies idling on both channels and gives the verdict from the checker
// ----------------------------------------------------------------------------
module testbench;

    localparam int IDLE_LIMIT = 20000;   // cycles with no transfer at all
    localparam int LONG_HOLD  = 3000;    // receiver hold-off to back the block up

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [30:0]        rad;
        logic [30:0]        mass;
        logic               second;
    } body_t;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_in_valid;
    logic                               o_in_stall;
    logic signed [spcr_pkg::WORD_W-1:0] i_pos_x;
    logic signed [spcr_pkg::WORD_W-1:0] i_pos_y;
    logic signed [spcr_pkg::WORD_W-1:0] i_pos_z;
    logic signed [spcr_pkg::WORD_W-1:0] i_vel_x;
    logic signed [spcr_pkg::WORD_W-1:0] i_vel_y;
    logic signed [spcr_pkg::WORD_W-1:0] i_vel_z;
    logic [spcr_pkg::MAG_W-1:0]         i_radius;
    logic [spcr_pkg::MAG_W-1:0]         i_mass;
    logic                               i_second_of_pair;
    logic                               o_out_valid;
    logic                               i_out_stall;
    logic                               o_body_select;
    logic signed [spcr_pkg::WORD_W-1:0] o_new_vel_x;
    logic signed [spcr_pkg::WORD_W-1:0] o_new_vel_y;
    logic signed [spcr_pkg::WORD_W-1:0] o_new_vel_z;
    logic                               o_collided;
    logic                               o_last_of_pair;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [spcr_pkg::REST_W-1:0]        i_restitution;

    int fail_count;
    int pending;
    int tx_idle_pct;     // chance in a hundred that the sender skips a cycle
    int rx_idle_pct;     // chance in a hundred that the receiver stalls a cycle
    bit hold_req;        // asks the receiver for one long hold-off
    int quiet_cycles;

    sphere_pair_collision_response u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .i_vel_x          (i_vel_x),
        .i_vel_y          (i_vel_y),
        .i_vel_z          (i_vel_z),
        .i_radius         (i_radius),
        .i_mass           (i_mass),
        .i_second_of_pair (i_second_of_pair),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_body_select    (o_body_select),
        .o_new_vel_x      (o_new_vel_x),
        .o_new_vel_y      (o_new_vel_y),
        .o_new_vel_z      (o_new_vel_z),
        .o_collided       (o_collided),
        .o_last_of_pair   (o_last_of_pair),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_restitution    (i_restitution)
    );

    sphere_pair_response_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .i_vel_x          (i_vel_x),
        .i_vel_y          (i_vel_y),
        .i_vel_z          (i_vel_z),
        .i_radius         (i_radius),
        .i_mass           (i_mass),
        .i_second_of_pair (i_second_of_pair),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_body_select    (o_body_select),
        .i_new_vel_x      (o_new_vel_x),
        .i_new_vel_y      (o_new_vel_y),
        .i_new_vel_z      (o_new_vel_z),
        .i_collided       (o_collided),
        .i_last_of_pair   (o_last_of_pair),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_restitution    (i_restitution),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog: the run is stuck if nothing moves on any channel for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random stall, or one long hold-off when asked
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // signed word with its magnitude limited to about 2^(bits-1)
    function automatic logic signed [31:0] rnd_word(input int bits);
        logic signed [31:0] w;
        w = $urandom;
        return w >>> (32 - bits);
    endfunction

    function automatic body_t mk_body(input longint px, input longint py, input longint pz,
                                      input longint vx, input longint vy, input longint vz,
                                      input longint rad, input longint mass, input bit second);
        body_t b;
        b.px = px; b.py = py; b.pz = pz;
        b.vx = vx; b.vy = vy; b.vz = vz;
        b.rad = rad; b.mass = mass; b.second = second;
        return b;
    endfunction

    // one body transfer; valid stays up afterwards until the next call decides
    task automatic offer(input body_t b);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_pos_x          <= b.px;
        i_pos_y          <= b.py;
        i_pos_z          <= b.pz;
        i_vel_x          <= b.vx;
        i_vel_y          <= b.vy;
        i_vel_z          <= b.vz;
        i_radius         <= b.rad;
        i_mass           <= b.mass;
        i_second_of_pair <= b.second;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_restitution(input logic [spcr_pkg::REST_W-1:0] value);
        drain();
        i_cfg_valid   <= 1'b1;
        i_restitution <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
    endtask

    // well-formed pair: b placed near a so that overlap is common
    task automatic near_pair();
        body_t a;
        body_t b;
        int    span;
        span = $urandom_range(4, 26);
        a.px = rnd_word($urandom_range(span, 32));
        a.py = rnd_word($urandom_range(span, 32));
        a.pz = rnd_word($urandom_range(span, 32));
        b.px = a.px + rnd_word(span);
        b.py = a.py + rnd_word(span);
        b.pz = a.pz + rnd_word(span);
        a.vx = rnd_word($urandom_range(4, 32));
        a.vy = rnd_word($urandom_range(4, 32));
        a.vz = rnd_word($urandom_range(4, 32));
        b.vx = rnd_word($urandom_range(4, 32));
        b.vy = rnd_word($urandom_range(4, 32));
        b.vz = rnd_word($urandom_range(4, 32));
        a.rad = ($urandom & 32'h7fff_ffff) >> (31 - span);
        b.rad = ($urandom & 32'h7fff_ffff) >> (31 - span);
        if ($urandom_range(15) == 0) a.rad = $urandom;
        a.mass = ($urandom_range(19) == 0) ? 0 : ($urandom >> $urandom_range(1, 31));
        b.mass = ($urandom_range(19) == 0) ? 0 : ($urandom >> $urandom_range(1, 31));
        a.second = 1'b0;
        b.second = 1'b1;
        offer(a);
        offer(b);
    endtask

    task automatic random_phase(input int n_items, input int tx_pct, input int rx_pct);
        int    sent;
        body_t b;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 85) begin
                near_pair();
                sent += 2;
            end else begin
                // noise: any body, any role, so broken sequences come up too
                b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     31'($urandom), 31'($urandom), 1'($urandom)};
                offer(b);
                sent += 1;
            end
        end
    endtask

    localparam longint ONE  = 65536;
    localparam longint PMAX = 64'sd2147483647;
    localparam longint PMIN = -64'sd2147483648;
    localparam longint RMAX = 64'd2147483647;

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_pos_x          = '0;
        i_pos_y          = '0;
        i_pos_z          = '0;
        i_vel_x          = '0;
        i_vel_y          = '0;
        i_vel_z          = '0;
        i_radius         = '0;
        i_mass           = '0;
        i_second_of_pair = 1'b0;
        i_cfg_valid      = 1'b0;
        i_restitution    = '0;
        tx_idle_pct      = 9;
        rx_idle_pct      = 80;
        hold_req         = 1'b0;
        quiet_cycles     = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, restitution still at its reset value of one half
        // body b before any body a: partner is the all-zero massless body
        offer(mk_body(ONE, 0, 0, -ONE, 0, 0, 2 * ONE, ONE, 1));
        // head-on approach
        offer(mk_body(0, 0, 0, ONE, 0, 0, ONE, 2 * ONE, 0));
        offer(mk_body(3 * ONE / 2, 0, 0, -ONE, 0, 0, ONE, ONE, 1));
        // separating pair that overlaps
        offer(mk_body(0, 0, 0, -ONE, 0, 0, ONE, ONE, 0));
        offer(mk_body(ONE, 0, 0, ONE, 0, 0, ONE, ONE, 1));
        // far apart
        offer(mk_body(0, 0, 0, ONE, 0, 0, ONE, ONE, 0));
        offer(mk_body(0, 10 * ONE, 0, -ONE, 0, 0, ONE, ONE, 1));
        // coincident centres
        offer(mk_body(5, -7, 9, ONE, 2, 3, 0, ONE, 0));
        offer(mk_body(5, -7, 9, -ONE, 4, 5, 0, ONE, 1));
        // both massless, approaching
        offer(mk_body(0, 0, 0, ONE, 0, 0, ONE, 0, 0));
        offer(mk_body(ONE, ONE, 0, -ONE, -ONE, 0, ONE, 0, 1));
        // two a bodies in a row, the second one counts
        offer(mk_body(PMAX, PMAX, PMAX, 9 * ONE, 0, 0, 0, 3, 0));
        offer(mk_body(ONE, -ONE, ONE / 2, 0, ONE, -ONE, ONE, ONE, 0));
        offer(mk_body(0, 0, 0, ONE, -ONE, 0, ONE, 7 * ONE, 1));
        // extreme corners, too far apart to touch even at full radius
        offer(mk_body(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, RMAX, RMAX, 0));
        offer(mk_body(PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, RMAX, RMAX, 1));
        // heavy fast closing pair at the extreme velocities
        offer(mk_body(0, 0, 0, PMIN, PMIN, PMIN, RMAX, RMAX, 0));
        offer(mk_body(-ONE, -ONE, -ONE, PMAX, PMAX, PMAX, RMAX, RMAX, 1));
        // lopsided masses on a skew axis
        offer(mk_body(ONE, 2 * ONE, -3 * ONE, -ONE, 0, ONE, 4 * ONE, RMAX, 0));
        offer(mk_body(0, 0, 0, ONE, ONE, -ONE, 4 * ONE, 1, 1));

        // random part over several restitution settings
        write_restitution(0);
        hold_req = 1'b1;
        random_phase(300, 9, 80);
        write_restitution(spcr_pkg::REST_ONE);
        random_phase(300, 9, 80);
        write_restitution('1);
        random_phase(300, 80, 9);
        write_restitution(spcr_pkg::REST_W'($urandom_range(0, 65536)));
        hold_req = 1'b1;
        random_phase(300, 80, 9);
        write_restitution(1);
        random_phase(300, 0, 0);
        write_restitution(spcr_pkg::REST_W'($urandom));
        random_phase(300, 0, 0);

        drain();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
